### hw/rtl/iss_pkg.sv
// Shared operation codes and controller/datapath interface types for the stack.
`timescale 1ns / 1ps

package iss_pkg;

	localparam int unsigned ModeW  = 3;
	localparam int unsigned WordW  = 32;
	localparam int unsigned CapW   = 7;
	localparam int unsigned FidxW  = 6;
	localparam int unsigned CountW = 7;

	localparam logic [ModeW-1:0] MODE_PUSH   = 3'd0;
	localparam logic [ModeW-1:0] MODE_POP    = 3'd1;
	localparam logic [ModeW-1:0] MODE_PEEK   = 3'd2;
	localparam logic [ModeW-1:0] MODE_SEARCH = 3'd3;
	localparam logic [ModeW-1:0] MODE_CLEAR  = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic start;       // item accepted this cycle
		logic read_done;   // pop/peek data is in the read register
		logic search_step; // compare one entry, move down one
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;       // no stored entries
		logic hit;         // entry in the read register matches
		logic last;        // compared entry is index zero
	} sts_t;

endpackage

### hw/rtl/iss_ctrl.sv
// Controller state machine: sequences one item through read, search and result.
`timescale 1ns / 1ps

module iss_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [iss_pkg::ModeW-1:0] mode,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  iss_pkg::sts_t          sts,
	output iss_pkg::cmd_t          cmd
);
	import iss_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_SRCH = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign accept    = in_valid && in_ready;

	assign cmd.start       = accept;
	assign cmd.read_done   = (state_q == S_READ);
	assign cmd.search_step = (state_q == S_SRCH);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if ((mode == MODE_POP || mode == MODE_PEEK) && !sts.empty)
						state_d = S_READ;
					else if (mode == MODE_SEARCH && !sts.empty)
						state_d = S_SRCH;
					else
						state_d = S_OUT;
				end
			end
			S_READ: state_d = S_OUT;
			S_SRCH: begin
				if (sts.hit || sts.last)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

### hw/rtl/iss_datapath.sv
// Datapath: stack store, count, capacity register, search index and result registers.
`timescale 1ns / 1ps

module iss_datapath #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iss_pkg::cmd_t                 cmd,
	output iss_pkg::sts_t                 sts,
	input  logic [iss_pkg::ModeW-1:0]     mode,
	input  logic signed [iss_pkg::WordW-1:0] value,
	input  logic                          cfg_we,
	input  logic [iss_pkg::CapW-1:0]      cfg_data,
	output logic                          status,
	output logic signed [iss_pkg::WordW-1:0] data,
	output logic [iss_pkg::FidxW-1:0]     found_index,
	output logic [iss_pkg::CountW-1:0]    count,
	output logic                          is_empty,
	output logic                          is_full
);
	import iss_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned EW = (CW > CapW) ? CW : CapW;
	localparam logic [EW-1:0] DepthE = EW'(DEPTH);

	logic [WordW-1:0] mem [DEPTH];
	logic [WordW-1:0] rd_q;
	logic [AW-1:0]    raddr;
	logic             we;

	logic [CW-1:0]    count_q;
	logic [CapW-1:0]  cap_q;
	logic [AW-1:0]    idx_q;
	logic [WordW-1:0] key_q;
	logic             pop_q;
	logic             status_q;
	logic [WordW-1:0] data_q;
	logic [AW-1:0]    fidx_q;

	logic [EW-1:0]    cap_e;
	logic [EW-1:0]    effcap;
	logic [EW-1:0]    count_e;
	logic             can_push;

	assign cap_e    = EW'(cap_q);
	assign effcap   = (cap_e > DepthE) ? DepthE : cap_e;
	assign count_e  = EW'(count_q);
	assign can_push = (count_e < effcap);

	assign sts.empty = (count_q == '0);
	assign sts.hit   = (rd_q == key_q);
	assign sts.last  = (idx_q == '0);

	// idle: fetch the top entry; search: fetch the one below the compared entry
	assign raddr = cmd.search_step ? (idx_q - 1'b1) : AW'(count_q - 1'b1);
	assign we    = cmd.start && (mode == MODE_PUSH) && can_push;

	always_ff @(posedge clk) begin
		if (we)
			mem[AW'(count_q)] <= value;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CapW'(64);
		end else begin
			if (cfg_we)
				cap_q <= cfg_data;
			if (cmd.start) begin
				if (we)
					count_q <= count_q + 1'b1;
				else if (mode == MODE_CLEAR)
					count_q <= '0;
			end else if (cmd.read_done && pop_q) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q  <= value;
			pop_q  <= (mode == MODE_POP);
			idx_q  <= AW'(count_q - 1'b1);
			data_q <= '0;
			fidx_q <= '0;
			case (mode)
				MODE_PUSH:   status_q <= !can_push;
				MODE_POP,
				MODE_PEEK,
				MODE_SEARCH: status_q <= sts.empty;
				MODE_CLEAR:  status_q <= 1'b0;
				default:     status_q <= 1'b1;
			endcase
		end else if (cmd.read_done) begin
			data_q   <= rd_q;
			status_q <= 1'b0;
		end else if (cmd.search_step) begin
			if (sts.hit) begin
				status_q <= 1'b0;
				fidx_q   <= idx_q;
			end else if (sts.last) begin
				status_q <= 1'b1;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	assign status      = status_q;
	assign data        = data_q;
	assign found_index = FidxW'(fidx_q);
	assign count       = CountW'(count_q);
	assign is_empty    = (count_q == '0);
	assign is_full     = (count_e >= effcap);

endmodule

### hw/rtl/integer_stack_with_search.sv
// Top level of the bounded integer stack with search.
`timescale 1ns / 1ps

// Bounded LIFO of signed 32-bit words, DEPTH entries in a block RAM with a
// registered read port. One item is handled at a time; in_ready is high only
// while the block is idle. Push, clear and an unknown mode go straight to the
// result; pop and peek first do one RAM read, unless the stack is empty. Search
// walks down from the top, one entry per cycle through the RAM read port,
// comparing at most the current count of entries. The result then stays on
// the output until out_ready takes it, and the block can accept the next item
// in the cycle after that. count and found_index
// report their low 7 and 6 bits. Capacity writes are taken at any time
// (cfg_ready is tied high) but must only be issued while the block is idle.
module integer_stack_with_search #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [iss_pkg::ModeW-1:0]         mode,
	input  logic signed [iss_pkg::WordW-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              status,
	output logic signed [iss_pkg::WordW-1:0]  data,
	output logic [iss_pkg::FidxW-1:0]         found_index,
	output logic [iss_pkg::CountW-1:0]        count,
	output logic                              is_empty,
	output logic                              is_full,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [iss_pkg::CapW-1:0]          cfg_data
);
	import iss_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	iss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	iss_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.value       (value),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.status      (status),
		.data        (data),
		.found_index (found_index),
		.count       (count),
		.is_empty    (is_empty),
		.is_full     (is_full)
	);

endmodule
